/* hdl/vcd_pkg.sv */
// ----------------------------------------------------------------------------
// vcd_pkg: shared types for the Vorbis comment deframer
// Parse phase codes, status codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package vcd_pkg;

   // Parse phase, one-hot
   typedef enum logic [5:0] {
      PH_VLEN   = 6'b000001,
      PH_VTEXT  = 6'b000010,
      PH_CCOUNT = 6'b000100,
      PH_CLEN   = 6'b001000,
      PH_CTEXT  = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      ST_PENDING   = 2'd0,
      ST_ACCEPTED  = 2'd1,
      ST_TRUNCATED = 2'd2,
      ST_TRAILING  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic        is_vendor_text;
      logic        is_comment_text;
      logic [31:0] comment_number;
      logic        comment_end;
      status_type  status;
   } result_type;

endpackage

`default_nettype wire

/* hdl/vcd_if.sv */
// ----------------------------------------------------------------------------
// vcd_if: channel interfaces for the Vorbis comment deframer
// Byte request channel, result channel and control register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface vcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       payload_last;

   modport source (output valid, output data_byte, output payload_last, input ready);
   modport sink   (input valid, input data_byte, input payload_last, output ready);
endinterface

interface vcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_out;
   logic        is_vendor_text;
   logic        is_comment_text;
   logic [31:0] comment_number;
   logic        comment_end;
   logic [1:0]  status;

   modport source (output valid, output byte_out, output is_vendor_text,
                   output is_comment_text, output comment_number,
                   output comment_end, output status, input ready);
   modport sink   (input valid, input byte_out, input is_vendor_text,
                   input is_comment_text, input comment_number,
                   input comment_end, input status, output ready);
endinterface

interface vcd_csr_if;
   logic valid;
   logic ready;
   logic reject_trailing;

   modport source (output valid, output reject_trailing, input ready);
   modport sink   (input valid, input reject_trailing, output ready);
endinterface

`default_nettype wire

/* hdl/vcd_parse.sv */
// ----------------------------------------------------------------------------
// vcd_parse: payload parse state and per-byte decode
// Holds the field/length counters; result is combinational from state and
// the staged byte, state commits on fire.
// ----------------------------------------------------------------------------
`default_nettype none

module vcd_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic [7:0]         data_byte,
   input  wire logic               payload_last,
   input  wire logic               reject_trailing,
   output vcd_pkg::result_type     result
);

   vcd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  field_idx_ff, field_idx_in;
   logic [31:0] length_assembly_ff, length_assembly_in;
   logic [31:0] bytes_remaining_ff, bytes_remaining_in;
   logic [31:0] comments_remaining_ff, comments_remaining_in;
   logic [31:0] comment_index_ff, comment_index_in;
   logic        saw_trailing_ff, saw_trailing_in;

   logic [31:0] asm_merged;
   logic        field_done;
   logic        rem_last;
   logic        cmt_last;

   always_comb begin
      asm_merged = length_assembly_ff;
      asm_merged[{field_idx_ff, 3'b000} +: 8] = data_byte;
      field_done = (field_idx_ff == 2'd3);
      rem_last   = (bytes_remaining_ff == 32'd1);
      cmt_last   = (comments_remaining_ff == 32'd1);

      phase_in              = phase_ff;
      field_idx_in          = field_idx_ff;
      length_assembly_in    = length_assembly_ff;
      bytes_remaining_in    = bytes_remaining_ff;
      comments_remaining_in = comments_remaining_ff;
      comment_index_in      = comment_index_ff;
      saw_trailing_in       = saw_trailing_ff;

      result                 = '0;
      result.byte_out        = data_byte;
      result.status          = vcd_pkg::ST_PENDING;

      unique case (phase_ff)
         vcd_pkg::PH_VLEN: begin
            length_assembly_in = asm_merged;
            field_idx_in       = field_idx_ff + 2'd1;
            if (field_done) begin
               bytes_remaining_in = asm_merged;
               phase_in = (asm_merged == 32'd0) ? vcd_pkg::PH_CCOUNT : vcd_pkg::PH_VTEXT;
            end
         end
         vcd_pkg::PH_VTEXT: begin
            result.is_vendor_text = 1'b1;
            bytes_remaining_in    = bytes_remaining_ff - 32'd1;
            if (rem_last) begin
               phase_in = vcd_pkg::PH_CCOUNT;
            end
         end
         vcd_pkg::PH_CCOUNT: begin
            length_assembly_in = asm_merged;
            field_idx_in       = field_idx_ff + 2'd1;
            if (field_done) begin
               comments_remaining_in = asm_merged;
               phase_in = (asm_merged == 32'd0) ? vcd_pkg::PH_DONE : vcd_pkg::PH_CLEN;
            end
         end
         vcd_pkg::PH_CLEN: begin
            result.comment_number = comment_index_ff;
            length_assembly_in    = asm_merged;
            field_idx_in          = field_idx_ff + 2'd1;
            if (field_done) begin
               bytes_remaining_in = asm_merged;
               if (asm_merged == 32'd0) begin
                  // empty comment ends on its last length byte
                  result.comment_end    = 1'b1;
                  comment_index_in      = comment_index_ff + 32'd1;
                  comments_remaining_in = comments_remaining_ff - 32'd1;
                  phase_in = cmt_last ? vcd_pkg::PH_DONE : vcd_pkg::PH_CLEN;
               end else begin
                  phase_in = vcd_pkg::PH_CTEXT;
               end
            end
         end
         vcd_pkg::PH_CTEXT: begin
            result.comment_number  = comment_index_ff;
            result.is_comment_text = 1'b1;
            bytes_remaining_in     = bytes_remaining_ff - 32'd1;
            if (rem_last) begin
               result.comment_end    = 1'b1;
               comment_index_in      = comment_index_ff + 32'd1;
               comments_remaining_in = comments_remaining_ff - 32'd1;
               phase_in = cmt_last ? vcd_pkg::PH_DONE : vcd_pkg::PH_CLEN;
            end
         end
         default: begin
            saw_trailing_in = 1'b1;
         end
      endcase

      if (payload_last) begin
         if (phase_in != vcd_pkg::PH_DONE) begin
            result.status = vcd_pkg::ST_TRUNCATED;
         end else if (saw_trailing_in && reject_trailing) begin
            result.status = vcd_pkg::ST_TRAILING;
         end else begin
            result.status = vcd_pkg::ST_ACCEPTED;
         end
         phase_in              = vcd_pkg::PH_VLEN;
         field_idx_in          = 2'd0;
         length_assembly_in    = '0;
         bytes_remaining_in    = '0;
         comments_remaining_in = '0;
         comment_index_in      = '0;
         saw_trailing_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff              <= vcd_pkg::PH_VLEN;
         field_idx_ff          <= 2'd0;
         length_assembly_ff    <= '0;
         bytes_remaining_ff    <= '0;
         comments_remaining_ff <= '0;
         comment_index_ff      <= '0;
         saw_trailing_ff       <= 1'b0;
      end else if (fire) begin
         phase_ff              <= phase_in;
         field_idx_ff          <= field_idx_in;
         length_assembly_ff    <= length_assembly_in;
         bytes_remaining_ff    <= bytes_remaining_in;
         comments_remaining_ff <= comments_remaining_in;
         comment_index_ff      <= comment_index_in;
         saw_trailing_ff       <= saw_trailing_in;
      end
   end

   // final byte always leaves a fresh parser behind
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && payload_last) |=> (phase_ff == vcd_pkg::PH_VLEN && field_idx_ff == 2'd0
                                  && comment_index_ff == 32'd0 && !saw_trailing_ff))
      else $error("parse state not cleared after final byte");

   // comment end only comes out of the comment phases
   a_end_phase: assert property (@(posedge clock) disable iff (reset)
      result.comment_end |-> (phase_ff == vcd_pkg::PH_CLEN || phase_ff == vcd_pkg::PH_CTEXT))
      else $error("comment end outside comment phases");

   // text counters never run empty while text is being read
   a_text_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == vcd_pkg::PH_VTEXT || phase_ff == vcd_pkg::PH_CTEXT)
         |-> (bytes_remaining_ff != 32'd0))
      else $error("text phase with zero bytes remaining");

endmodule

`default_nettype wire

/* hdl/vorbis_comment_deframer_core.sv */
// A request byte is registered in the input stage, then in the result register, before its response is offered.
// Throughput: one byte per cycle, sustained, with rsp_bus.ready held high.
// While a response waits, the input stage takes one more byte and then drops
// ready; once the response is taken both stages move on the same edge.
// Reset: synchronous, active high; clears the pipeline and the parse state
// and sets reject_trailing to 1.
// ----------------------------------------------------------------------------
// vorbis_comment_deframer_core: Vorbis comment payload deframer
// Marks vendor and comment text bytes, numbers comments, flags comment ends
// and reports a status on the final payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vorbis_comment_deframer_core (
   input  wire logic  clock,
   input  wire logic  reset,
   vcd_req_if.sink    req_bus,
   vcd_rsp_if.source  rsp_bus,
   vcd_csr_if.sink    csr_bus
);

   // ---------------------------------------------------------------
   // Control register: write it only while the block is idle; the block itself does not enforce this.
   // ---------------------------------------------------------------
   logic reject_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_ff <= 1'b1;
      end else if (csr_bus.valid) begin
         reject_ff <= csr_bus.reject_trailing;
      end
   end

   // ---------------------------------------------------------------
   // Input stage: holds one byte until the result register can take
   // its decode. Ready stays high whenever the byte moves on.
   // ---------------------------------------------------------------
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       advance;
   logic       req_fire;

   assign advance        = s1_valid_ff && (!rsp_bus.valid || rsp_bus.ready);
   assign req_bus.ready  = !s1_valid_ff || advance;
   assign req_fire       = req_bus.valid && req_bus.ready;
   assign s1_valid_in    = req_fire || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_bus.data_byte;
         s1_last_ff <= req_bus.payload_last;
      end
   end

   // ---------------------------------------------------------------
   // Decode: parse state advances on the same edge the result is
   // captured, so state and output never drift apart.
   // ---------------------------------------------------------------
   vcd_pkg::result_type decode;

   vcd_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .fire            (advance),
      .data_byte       (s1_byte_ff),
      .payload_last    (s1_last_ff),
      .reject_trailing (reject_ff),
      .result          (decode)
   );

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic                out_valid_ff, out_valid_in;
   vcd_pkg::result_type out_data_ff;

   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= decode;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.byte_out        = out_data_ff.byte_out;
   assign rsp_bus.is_vendor_text  = out_data_ff.is_vendor_text;
   assign rsp_bus.is_comment_text = out_data_ff.is_comment_text;
   assign rsp_bus.comment_number  = out_data_ff.comment_number;
   assign rsp_bus.comment_end     = out_data_ff.comment_end;
   assign rsp_bus.status          = out_data_ff.status;

   // input only backs up when both stages are full and the sink stalls
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid_ff && out_valid_ff && !rsp_bus.ready))
      else $error("request stalled with room in the pipeline");

   // a decoded byte always lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result lost after advance");

   // a stalled response holds steady
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> (rsp_bus.valid && $stable(out_data_ff)))
      else $error("response changed while stalled");

endmodule

`default_nettype wire

/* tb/vorbis_comment_deframer_core_tb.sv */
// ----------------------------------------------------------------------------
// vorbis_comment_deframer_core_tb: self-checking bench for the comment deframer
// Streams Vorbis comment payloads (clean, cut short, oversized and plain
// noise) through the byte channel with random gaps and response stalls,
// predicts every response with an independent parser model and checks each
// response field by field. The reject_trailing register is rewritten between
// payloads while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module vorbis_comment_deframer_core_tb;

   localparam int unsigned MAX_WAIT      = 13;   // longest gap or stall per transfer
   localparam int unsigned SETTLE_CYCLES = 4;    // quiet cycles before a register write
   localparam int unsigned END_CYCLES    = 10;   // quiet cycles before the verdict
   localparam int unsigned TARGET_BYTES  = 950;
   localparam int unsigned SIDE_SEND     = 0;
   localparam int unsigned SIDE_RECV     = 1;

   typedef enum logic {OP_PAYLOAD_BYTE, OP_SET_REJECT} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [7:0]  data_byte;
      logic        is_last;
      logic        reject;
   } bus_op_type;

   typedef enum logic [4:0] {
      DRV_FETCH = 5'b00001,
      DRV_GAP   = 5'b00010,
      DRV_SEND  = 5'b00100,
      DRV_DRAIN = 5'b01000,
      DRV_WRITE = 5'b10000
   } drv_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Channel drive values; known from time zero, updated only at rising edges
   logic       req_valid  = 1'b0;
   logic [7:0] req_data   = 8'h00;
   logic       req_last   = 1'b0;
   logic       rsp_ready  = 1'b0;
   logic       csr_valid  = 1'b0;
   logic       csr_flag   = 1'b1;

   vcd_req_if req_bus();
   vcd_rsp_if rsp_bus();
   vcd_csr_if csr_bus();

   assign req_bus.valid           = req_valid;
   assign req_bus.data_byte       = req_data;
   assign req_bus.payload_last    = req_last;
   assign rsp_bus.ready           = rsp_ready;
   assign csr_bus.valid           = csr_valid;
   assign csr_bus.reject_trailing = csr_flag;

   vorbis_comment_deframer_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Parser model: mirrors the block's parse state, advanced once per
   // accepted byte transfer by the monitor below.
   // -------------------------------------------------------------------------
   vcd_pkg::phase_type ps_phase;
   logic [1:0]  ps_lane;            // byte position inside a 32-bit LE field
   logic [31:0] ps_field;           // field being assembled
   logic [31:0] ps_left;            // text bytes still to come
   logic [31:0] ps_comments_left;
   logic [31:0] ps_comment_no;
   logic        ps_trailing;
   logic        cfg_reject;

   vcd_pkg::result_type expected_results [$];
   int unsigned owed_results = 0;   // queue depth as of the previous edge
   int unsigned error_count  = 0;

   function automatic void clear_parse_state();
      ps_phase         = vcd_pkg::PH_VLEN;
      ps_lane          = 2'd0;
      ps_field         = '0;
      ps_left          = '0;
      ps_comments_left = '0;
      ps_comment_no    = '0;
      ps_trailing      = 1'b0;
   endfunction

   // Places one byte into the LE field; true once the fourth byte is in.
   function automatic bit take_length_byte(input logic [7:0] b);
      ps_field[ps_lane*8 +: 8] = b;
      if (ps_lane == 2'd3) begin
         ps_lane = 2'd0;
         return 1'b1;
      end
      ps_lane = ps_lane + 2'd1;
      return 1'b0;
   endfunction

   function automatic void close_comment();
      ps_comment_no    = ps_comment_no + 1;
      ps_comments_left = ps_comments_left - 1;
      ps_phase         = (ps_comments_left == 0) ? vcd_pkg::PH_DONE : vcd_pkg::PH_CLEN;
   endfunction

   function automatic vcd_pkg::result_type parse_byte(input logic [7:0] b,
                                                       input logic is_last);
      vcd_pkg::result_type r;
      r          = '0;
      r.byte_out = b;
      unique case (ps_phase)
         vcd_pkg::PH_VLEN: begin
            if (take_length_byte(b)) begin
               ps_left  = ps_field;
               ps_phase = (ps_field == 0) ? vcd_pkg::PH_CCOUNT : vcd_pkg::PH_VTEXT;
            end
         end
         vcd_pkg::PH_VTEXT: begin
            r.is_vendor_text = 1'b1;
            ps_left          = ps_left - 1;
            if (ps_left == 0)
               ps_phase = vcd_pkg::PH_CCOUNT;
         end
         vcd_pkg::PH_CCOUNT: begin
            if (take_length_byte(b)) begin
               ps_comments_left = ps_field;
               ps_phase = (ps_field == 0) ? vcd_pkg::PH_DONE : vcd_pkg::PH_CLEN;
            end
         end
         vcd_pkg::PH_CLEN: begin
            r.comment_number = ps_comment_no;
            if (take_length_byte(b)) begin
               ps_left = ps_field;
               // empty comment ends on its last length byte
               if (ps_field == 0) begin
                  r.comment_end = 1'b1;
                  close_comment();
               end else begin
                  ps_phase = vcd_pkg::PH_CTEXT;
               end
            end
         end
         vcd_pkg::PH_CTEXT: begin
            r.comment_number  = ps_comment_no;
            r.is_comment_text = 1'b1;
            ps_left           = ps_left - 1;
            if (ps_left == 0) begin
               r.comment_end = 1'b1;
               close_comment();
            end
         end
         default: ps_trailing = 1'b1;   // past the last comment
      endcase
      if (is_last) begin
         if (ps_phase != vcd_pkg::PH_DONE)
            r.status = vcd_pkg::ST_TRUNCATED;
         else if (ps_trailing && cfg_reject)
            r.status = vcd_pkg::ST_TRAILING;
         else
            r.status = vcd_pkg::ST_ACCEPTED;
         clear_parse_state();
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] due);
      $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, due);
      error_count++;
   endtask

   // -------------------------------------------------------------------------
   // Idle draws. Each side mostly waits a random gap, up to MAX_WAIT, per transfer, but
   // now and then enters a calm stretch of back-to-back transfers.
   // -------------------------------------------------------------------------
   int unsigned calm_left [2] = '{0, 0};

   function automatic int unsigned draw_wait(input int unsigned side);
      if (calm_left[side] != 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left[side] = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus build: payloads are assembled in frame_q, then moved to op_q
   // with payload_last on the final byte kept.
   // -------------------------------------------------------------------------
   bus_op_type  op_q [$];
   logic [7:0]  frame_q [$];
   int unsigned bytes_queued = 0;

   task automatic add_byte(input logic [7:0] b);
      frame_q.insert(frame_q.size(), b);
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         frame_q.insert(frame_q.size(), w[i*8 +: 8]);
   endtask

   task automatic emit_frame(input int unsigned keep);
      bus_op_type op;
      for (int unsigned i = 0; i < keep; i++) begin
         op.kind      = OP_PAYLOAD_BYTE;
         op.data_byte = frame_q[i];
         op.is_last   = (i == keep - 1);
         op.reject    = 1'b0;
         op_q.insert(op_q.size(), op);
      end
      bytes_queued += keep;
      frame_q.delete();
   endtask

   task automatic push_reject(input logic value);
      bus_op_type op;
      op.kind      = OP_SET_REJECT;
      op.data_byte = 8'h00;
      op.is_last   = 1'b0;
      op.reject    = value;
      op_q.insert(op_q.size(), op);
   endtask

   // Clean payload with random sizes and text; sometimes trailing bytes.
   task automatic build_wellformed();
      int unsigned vlen;
      int unsigned ncom;
      int unsigned clen;
      vlen = $urandom_range(0, 5);
      add_word(vlen);
      repeat (vlen) add_byte(8'($urandom_range(0, 255)));
      ncom = $urandom_range(0, 3);
      add_word(ncom);
      repeat (ncom) begin
         clen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         add_word(clen);
         repeat (clen) add_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
   endtask

   // A length or count far beyond what follows; always ends truncated.
   task automatic build_oversized();
      logic [31:0] huge;
      huge = $urandom | 32'h0100_0000;
      case ($urandom_range(0, 2))
         0: add_word(huge);
         1: begin
            add_word(0);
            add_word(huge);
         end
         default: begin
            add_word(0);
            add_word(1);
            add_word(huge);
         end
      endcase
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
   endtask

   // -------------------------------------------------------------------------
   // Driver: pops op_q. Payload bytes go out on the request channel after a
   // random gap; a register write first waits for every expected response
   // plus a quiet settle count of SETTLE_CYCLES, so the block is idle when it lands.
   // -------------------------------------------------------------------------
   drv_state_type drv_state  = DRV_FETCH;
   int unsigned gap_left     = 0;
   int unsigned settle_count = 0;
   logic        write_value  = 1'b1;

   task automatic fetch_next_op();
      bus_op_type  op;
      int unsigned gap;
      if (op_q.size() == 0) begin
         req_valid <= 1'b0;
         drv_state <= DRV_FETCH;
      end else begin
         op = op_q.pop_front();
         if (op.kind == OP_SET_REJECT) begin
            req_valid    <= 1'b0;
            write_value  <= op.reject;
            settle_count <= 0;
            drv_state    <= DRV_DRAIN;
         end else begin
            req_data <= op.data_byte;
            req_last <= op.is_last;
            gap = draw_wait(SIDE_SEND);
            if (gap == 0) begin
               req_valid <= 1'b1;   // back-to-back: valid stays high
               drv_state <= DRV_SEND;
            end else begin
               req_valid <= 1'b0;
               gap_left  <= gap - 1;
               drv_state <= DRV_GAP;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         drv_state <= DRV_FETCH;
      end else begin
         unique case (drv_state)
            DRV_FETCH: fetch_next_op();
            DRV_GAP: begin
               if (gap_left == 0) begin
                  req_valid <= 1'b1;
                  drv_state <= DRV_SEND;
               end else begin
                  gap_left <= gap_left - 1;
               end
            end
            DRV_SEND: begin
               if (req_bus.ready)
                  fetch_next_op();
            end
            DRV_DRAIN: begin
               if (owed_results == 0 && !rsp_bus.valid) begin
                  if (settle_count == SETTLE_CYCLES) begin
                     csr_valid <= 1'b1;
                     csr_flag  <= write_value;
                     drv_state <= DRV_WRITE;
                  end else begin
                     settle_count <= settle_count + 1;
                  end
               end else begin
                  settle_count <= 0;
               end
            end
            DRV_WRITE: begin
               if (csr_bus.ready) begin
                  csr_valid <= 1'b0;
                  fetch_next_op();
               end
            end
            default: drv_state <= DRV_FETCH;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: tracks register writes and request transfers to build the
   // expected responses, checks each response transfer against the oldest
   // one, and applies random back-pressure on the response channel.
   // -------------------------------------------------------------------------
   int unsigned stall_left = 0;

   always @(posedge clock) begin : response_monitor
      vcd_pkg::result_type due;
      int unsigned stall;
      if (reset) begin
         clear_parse_state();
         cfg_reject = 1'b1;
         expected_results.delete();
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else begin
         if (csr_valid && csr_bus.ready)
            cfg_reject = csr_flag;
         if (req_valid && req_bus.ready)
            expected_results.insert(expected_results.size(),
                                    parse_byte(req_data, req_last));
         if (rsp_bus.valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response, byte_out",
                               32'(rsp_bus.byte_out), 32'd0);
            end else begin
               due = expected_results.pop_front();
               if (rsp_bus.byte_out !== due.byte_out)
                  report_mismatch("byte_out", 32'(rsp_bus.byte_out), 32'(due.byte_out));
               if (rsp_bus.is_vendor_text !== due.is_vendor_text)
                  report_mismatch("is_vendor_text", 32'(rsp_bus.is_vendor_text),
                                  32'(due.is_vendor_text));
               if (rsp_bus.is_comment_text !== due.is_comment_text)
                  report_mismatch("is_comment_text", 32'(rsp_bus.is_comment_text),
                                  32'(due.is_comment_text));
               if (rsp_bus.comment_number !== due.comment_number)
                  report_mismatch("comment_number", rsp_bus.comment_number,
                                  due.comment_number);
               if (rsp_bus.comment_end !== due.comment_end)
                  report_mismatch("comment_end", 32'(rsp_bus.comment_end),
                                  32'(due.comment_end));
               if (rsp_bus.status !== due.status)
                  report_mismatch("status", 32'(rsp_bus.status), 32'(due.status));
            end
            stall = draw_wait(SIDE_RECV);
            if (stall == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready  <= 1'b0;
               stall_left <= stall - 1;
            end
         end else if (!rsp_ready) begin
            if (stall_left == 0)
               rsp_ready <= 1'b1;
            else
               stall_left <= stall_left - 1;
         end
      end
      owed_results <= expected_results.size();
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin : test_sequence
      bit wrote_one;
      wrote_one = 1'b0;

      // Directed: vendor length 1, two comments, the first empty; accepted
      add_word(1);
      add_byte(8'hFF);
      add_word(2);
      add_word(0);
      add_word(1);
      add_byte(8'h80);
      emit_frame(frame_q.size());
      // Final flag on the very first byte: truncated
      add_byte(8'h00);
      emit_frame(1);
      // Empty vendor, zero comments, one trailing byte under reject mode
      add_word(0);
      add_word(0);
      add_byte(8'h7F);
      emit_frame(frame_q.size());

      // Random: mostly clean payloads, some cut short, oversized or noise
      push_reject(1'b0);
      while (bytes_queued < TARGET_BYTES) begin
         if (!wrote_one && bytes_queued > TARGET_BYTES / 2) begin
            push_reject(1'b1);
            wrote_one = 1'b1;
         end else if ($urandom_range(0, 11) == 0) begin
            push_reject(1'($urandom_range(0, 1)));
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
               build_wellformed();
               emit_frame(frame_q.size());
            end
            13, 14, 15: begin
               build_wellformed();
               emit_frame($urandom_range(1, frame_q.size() - 1));
            end
            16, 17: begin
               build_oversized();
               emit_frame(frame_q.size());
            end
            default: begin
               repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
               emit_frame(frame_q.size());
            end
         endcase
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (op_q.size() != 0 || drv_state != DRV_FETCH || owed_results != 0);
      repeat (END_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("TIMEOUT: %0d responses still owed", owed_results);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
hdl/vcd_pkg.sv
hdl/vcd_if.sv
hdl/vcd_parse.sv
hdl/vorbis_comment_deframer_core.sv
tb/vorbis_comment_deframer_core_tb.sv
